// ===== hdl/window_mode_informed_mean_filter_top_defines.svh =====
// assertion helpers shared by the filter modules
`ifndef WINDOW_MODE_INFORMED_MEAN_FILTER_TOP_DEFINES_SVH
`define WINDOW_MODE_INFORMED_MEAN_FILTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define WMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define WMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wmf_pkg.sv =====
package wmf_pkg;

  localparam int WINDOW_DEPTH  = 32;
  localparam int SAMPLE_BITS   = 16;
  localparam int AVG_BITS      = SAMPLE_BITS + 4;
  localparam int SPREAD_BITS   = 9;
  localparam int LEN_BITS      = 6;
  localparam int CNT_BITS      = $clog2(WINDOW_DEPTH + 1);
  localparam int ROT_BITS      = $clog2(WINDOW_DEPTH);
  localparam int SUM_BITS      = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int PROD_BITS     = SAMPLE_BITS + CNT_BITS + 1;
  localparam int DIV_BITS      = PROD_BITS + 5;
  localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DATA_BITS  = 3 * SAMPLE_BITS;
  localparam int RES_BITS      = 3 * SAMPLE_BITS + 6 * AVG_BITS + 3 * SPREAD_BITS;
  localparam int OUT_DATA_BITS = ((RES_BITS + 7) / 8) * 8;

  localparam logic [LEN_BITS-1:0] LENGTH_RESET = LEN_BITS'(30);
  localparam logic [LEN_BITS-1:0] LENGTH_MIN   = LEN_BITS'(2);

  // queued item: sample plus what the front decided about it
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
    logic [CNT_BITS-1:0]           n;
    logic                          produce;
  } wmf_item_t;

  typedef struct packed {
    logic [SPREAD_BITS-1:0]     spread_z;
    logic [SPREAD_BITS-1:0]     spread_y;
    logic [SPREAD_BITS-1:0]     spread_x;
    logic signed [AVG_BITS-1:0] blend_z;
    logic signed [AVG_BITS-1:0] blend_y;
    logic signed [AVG_BITS-1:0] blend_x;
    logic signed [AVG_BITS-1:0] average_z;
    logic signed [AVG_BITS-1:0] average_y;
    logic signed [AVG_BITS-1:0] average_x;
    logic signed [SAMPLE_BITS-1:0] mode_z;
    logic signed [SAMPLE_BITS-1:0] mode_y;
    logic signed [SAMPLE_BITS-1:0] mode_x;
  } wmf_result_t;

  typedef struct packed {
    logic                       start;
    logic signed [DIV_BITS-1:0] dividend;
    logic [CNT_BITS-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [DIV_BITS-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    KIND_AVG,
    KIND_BLEND,
    KIND_SPREAD
  } div_kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PASS1,
    B_PASS2,
    B_PREP,
    B_DIV_START,
    B_DIV_WAIT,
    B_OUT,
    B_INSERT
  } back_state_t;

endpackage

// ===== hdl/window_mode_informed_mean_filter_top.sv =====
// an accepted item reaches m_tvalid after two passes over the window registers
// and nine divisions on one shared serial divider, then the output register
// the back end works on one item at a time; an item with an empty window skips the
// passes and divisions; a two-item queue lets the input take items while the back end is busy
// reset: length register 30, fill count 0, queue and result register empty;
// window contents are not cleared and are only read once written
module window_mode_informed_mean_filter_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [wmf_pkg::LEN_BITS-1:0]     cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample_x, sample_y, sample_z
  input  logic [wmf_pkg::IN_DATA_BITS-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // mode_x/y/z, average_x/y/z, blend_x/y/z, spread_x/y/z, zero pad
  output logic [wmf_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  import wmf_pkg::*;

  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  wmf_item_t   q_wr_item;
  wmf_item_t   q_rd_item;
  wmf_result_t back_res;
  logic        back_valid;
  logic        back_ready;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  wmf_result_t out_res;
  logic        out_valid;

  wmf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wr_item)
  );

  wmf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  wmf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_rd_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (back_res),
    .res_valid (back_valid),
    .res_ready (back_ready),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  wmf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // output register
  assign back_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (back_ready) begin
      out_valid <= back_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (back_ready && back_valid) begin
      out_res <= back_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_BITS - RES_BITS){1'b0}}, out_res};

endmodule

// ===== hdl/wmf_front.sv =====
module wmf_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [wmf_pkg::LEN_BITS-1:0]    cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [wmf_pkg::IN_DATA_BITS-1:0] s_tdata,
  input  logic                            q_full,
  output logic                            q_push,
  output wmf_pkg::wmf_item_t              q_item
);
  import wmf_pkg::*;

  logic [LEN_BITS-1:0] window_length;
  logic [CNT_BITS-1:0] fill_count;
  logic [CNT_BITS-1:0] fill_count_next;
  logic [CNT_BITS-1:0] len_eff;
  logic [CNT_BITS-1:0] n_cur;
  logic [CNT_BITS:0]   n_plus;

  // length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LENGTH_RESET;
    end else if (cfg_wen) begin
      window_length <= cfg_wdata;
    end
  end

  // clamp length, size the window seen by this item
  always_comb begin
    if (window_length < LENGTH_MIN) begin
      len_eff = CNT_BITS'(LENGTH_MIN);
    end else if (CNT_BITS'(window_length) > CNT_BITS'(WINDOW_DEPTH)) begin
      len_eff = CNT_BITS'(WINDOW_DEPTH);
    end else begin
      len_eff = CNT_BITS'(window_length);
    end
    n_cur  = (fill_count < len_eff) ? fill_count : len_eff;
    n_plus = {1'b0, n_cur} + (CNT_BITS + 1)'(1);
    fill_count_next = (n_plus < {1'b0, len_eff}) ? n_plus[CNT_BITS-1:0] : len_eff;
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // classify: an empty window gives no result
  always_comb begin
    q_item.sample_x = s_tdata[SAMPLE_BITS-1:0];
    q_item.sample_y = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    q_item.sample_z = s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    q_item.n        = n_cur;
    q_item.produce  = (n_cur != '0);
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (q_push) begin
      fill_count <= fill_count_next;
    end
  end

endmodule

// ===== hdl/wmf_fifo.sv =====
`include "window_mode_informed_mean_filter_top_defines.svh"

module wmf_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wmf_pkg::wmf_item_t wr_item,
  input  logic               pop,
  output wmf_pkg::wmf_item_t rd_item,
  output logic               full,
  output logic               empty
);
  import wmf_pkg::*;

  wmf_item_t            slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full    = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_item = slots[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  `WMF_ASSERT_NOW(a_no_push_full, full, !push, "item pushed into full queue")
  `WMF_ASSERT_NOW(a_no_pop_empty, empty, !pop, "item popped from empty queue")
  `WMF_ASSERT_NEXT(a_push_fills, (push && !pop), !empty, "queue empty after push")

endmodule

// ===== hdl/wmf_div.sv =====
module wmf_div (
  input  logic              clk,
  input  logic              rst,
  input  wmf_pkg::div_req_t req,
  output wmf_pkg::div_rsp_t rsp
);
  import wmf_pkg::*;

  logic                    busy;
  logic                    done;
  logic                    neg;
  logic [DIV_CNT_BITS-1:0] step_cnt;
  logic [DIV_BITS-1:0]     acc;
  logic [CNT_BITS-1:0]     rem;
  logic [CNT_BITS-1:0]     dsor;
  logic [CNT_BITS:0]       trial;
  logic                    fits;

  // one restoring step
  assign trial = {rem, acc[DIV_BITS-1]};
  assign fits  = (trial >= {1'b0, dsor});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step_cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: magnitude divide, sign fixed at the end
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg      <= req.dividend[DIV_BITS-1];
      acc      <= req.dividend[DIV_BITS-1] ? DIV_BITS'(-req.dividend) : req.dividend;
      rem      <= '0;
      dsor     <= req.divisor;
      step_cnt <= DIV_CNT_BITS'(DIV_BITS - 1);
    end else if (busy) begin
      rem      <= fits ? CNT_BITS'(trial - {1'b0, dsor}) : trial[CNT_BITS-1:0];
      acc      <= {acc[DIV_BITS-2:0], fits};
      step_cnt <= step_cnt - DIV_CNT_BITS'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? DIV_BITS'(-acc) : acc;

endmodule

// ===== hdl/wmf_back.sv =====
`include "window_mode_informed_mean_filter_top_defines.svh"

module wmf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  wmf_pkg::wmf_item_t    q_item,
  input  logic                  q_empty,
  output logic                  q_pop,
  output wmf_pkg::wmf_result_t  res,
  output logic                  res_valid,
  input  logic                  res_ready,
  output wmf_pkg::div_req_t     div_req,
  input  wmf_pkg::div_rsp_t     div_rsp
);
  import wmf_pkg::*;

  back_state_t state;
  back_state_t state_next;

  wmf_item_t                      cur;
  logic signed [SAMPLE_BITS-1:0]  win [WINDOW_DEPTH][3];
  logic [WINDOW_DEPTH-1:0]        vmask;
  logic [ROT_BITS-1:0]            rot_cnt;
  logic signed [SUM_BITS-1:0]     sum    [3];
  logic signed [SAMPLE_BITS-1:0]  mode_v [3];
  logic [CNT_BITS-1:0]            mode_c [3];
  logic signed [SAMPLE_BITS-1:0]  run_v  [3];
  logic [CNT_BITS-1:0]            run_c  [3];
  logic signed [PROD_BITS-1:0]    prod_m [3];
  logic signed [PROD_BITS-1:0]    prod_r [3];
  logic [1:0]                     job_axis;
  div_kind_t                      job_kind;
  logic signed [SAMPLE_BITS-1:0]  res_mode   [3];
  logic signed [AVG_BITS-1:0]     res_avg    [3];
  logic signed [AVG_BITS-1:0]     res_blend  [3];
  logic [SPREAD_BITS-1:0]         res_spread [3];

  logic [WINDOW_DEPTH-1:0]        hit [3];
  logic [CNT_BITS-1:0]            cnt [3];
  logic                           last_rot;
  logic                           last_job;
  logic signed [SUM_BITS-1:0]     sum_sel;
  logic signed [PROD_BITS-1:0]    pm_sel;
  logic signed [PROD_BITS-1:0]    pr_sel;
  logic [CNT_BITS-1:0]            cm_sel;
  logic [CNT_BITS-1:0]            cr_sel;
  logic [CNT_BITS-1:0]            den_sel;
  logic [CNT_BITS-1:0]            rest_sel;
  logic signed [DIV_BITS-1:0]     num_sel;

  // occurrences of the value at the head of the rotating window
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < WINDOW_DEPTH; j++) begin
        hit[a][j] = vmask[j] && (win[j][a] == win[0][a]);
      end
      cnt[a] = CNT_BITS'($countones(hit[a]));
    end
  end

  assign last_rot = (rot_cnt == ROT_BITS'(WINDOW_DEPTH - 1));
  assign last_job = (job_axis == 2'd2) && (job_kind == KIND_SPREAD);

  // divider operands for the current job
  always_comb begin
    sum_sel  = sum[job_axis];
    pm_sel   = prod_m[job_axis];
    pr_sel   = prod_r[job_axis];
    cm_sel   = mode_c[job_axis];
    cr_sel   = run_c[job_axis];
    den_sel  = cm_sel + cr_sel;
    rest_sel = cur.n - den_sel;
    num_sel  = DIV_BITS'(pm_sel) + DIV_BITS'(pr_sel);
    div_req.start = (state == B_DIV_START);
    case (job_kind)
      KIND_AVG: begin
        div_req.dividend = DIV_BITS'(sum_sel) <<< 4;
        div_req.divisor  = cur.n;
      end
      KIND_BLEND: begin
        div_req.dividend = num_sel <<< 4;
        div_req.divisor  = den_sel;
      end
      KIND_SPREAD: begin
        div_req.dividend = {{(DIV_BITS - CNT_BITS){1'b0}}, rest_sel} << 8;
        div_req.divisor  = cur.n;
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = cur.n;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshakes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    res_valid  = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = q_item.produce ? B_PASS1 : B_INSERT;
        end
      end
      B_PASS1: begin
        if (last_rot) begin
          state_next = B_PASS2;
        end
      end
      B_PASS2: begin
        if (last_rot) begin
          state_next = B_PREP;
        end
      end
      B_PREP: state_next = B_DIV_START;
      B_DIV_START: state_next = B_DIV_WAIT;
      B_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = last_job ? B_OUT : B_DIV_START;
        end
      end
      B_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = B_INSERT;
        end
      end
      B_INSERT: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          cur     <= q_item;
          rot_cnt <= '0;
          for (int j = 0; j < WINDOW_DEPTH; j++) begin
            vmask[j] <= (CNT_BITS'(j) < q_item.n);
          end
          for (int a = 0; a < 3; a++) begin
            sum[a]    <= '0;
            mode_c[a] <= '0;
            mode_v[a] <= '0;
            run_c[a]  <= '0;
            run_v[a]  <= '0;
          end
        end
      end
      B_PASS1, B_PASS2: begin
        // rotate window and mask by one place
        for (int j = 0; j < WINDOW_DEPTH - 1; j++) begin
          win[j] <= win[j+1];
        end
        win[WINDOW_DEPTH-1] <= win[0];
        vmask   <= {vmask[0], vmask[WINDOW_DEPTH-1:1]};
        rot_cnt <= rot_cnt + ROT_BITS'(1);
        for (int a = 0; a < 3; a++) begin
          if (vmask[0]) begin
            if (state == B_PASS1) begin
              sum[a] <= sum[a] + SUM_BITS'(win[0][a]);
              if (cnt[a] > mode_c[a]) begin
                mode_c[a] <= cnt[a];
                mode_v[a] <= win[0][a];
              end
            end else if (win[0][a] != mode_v[a] && cnt[a] > run_c[a]) begin
              run_c[a] <= cnt[a];
              run_v[a] <= win[0][a];
            end
          end
        end
      end
      B_PREP: begin
        for (int a = 0; a < 3; a++) begin
          prod_m[a]   <= $signed({1'b0, mode_c[a]}) * mode_v[a];
          prod_r[a]   <= $signed({1'b0, run_c[a]}) * run_v[a];
          res_mode[a] <= mode_v[a];
        end
        job_axis <= '0;
        job_kind <= KIND_AVG;
      end
      B_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (job_kind)
            KIND_AVG: begin
              res_avg[job_axis] <= div_rsp.quotient[AVG_BITS-1:0];
              job_kind <= KIND_BLEND;
            end
            KIND_BLEND: begin
              res_blend[job_axis] <= div_rsp.quotient[AVG_BITS-1:0];
              job_kind <= KIND_SPREAD;
            end
            default: begin
              res_spread[job_axis] <= div_rsp.quotient[SPREAD_BITS-1:0];
              job_kind <= KIND_AVG;
              job_axis <= job_axis + 2'd1;
            end
          endcase
        end
      end
      B_INSERT: begin
        // new sample enters at the newest end
        for (int j = 1; j < WINDOW_DEPTH; j++) begin
          win[j] <= win[j-1];
        end
        win[0][0] <= cur.sample_x;
        win[0][1] <= cur.sample_y;
        win[0][2] <= cur.sample_z;
      end
      default: begin
      end
    endcase
  end

  // result assembly
  always_comb begin
    res.mode_x    = res_mode[0];
    res.mode_y    = res_mode[1];
    res.mode_z    = res_mode[2];
    res.average_x = res_avg[0];
    res.average_y = res_avg[1];
    res.average_z = res_avg[2];
    res.blend_x   = res_blend[0];
    res.blend_y   = res_blend[1];
    res.blend_z   = res_blend[2];
    res.spread_x  = res_spread[0];
    res.spread_y  = res_spread[1];
    res.spread_z  = res_spread[2];
  end

  `WMF_ASSERT_NOW(a_mode_found, (state == B_PASS2),
    (mode_c[0] != '0 && mode_c[1] != '0 && mode_c[2] != '0), "no mode after first pass")
  `WMF_ASSERT_NOW(a_div_done_wait, div_rsp.done, (state == B_DIV_WAIT),
    "divider finished outside wait state")
  `WMF_ASSERT_NEXT(a_div_start_busy, (state == B_DIV_START), (state == B_DIV_WAIT),
    "divider start not followed by wait")

endmodule

// ===== verif/window_mode_informed_mean_filter_top_tb.sv =====
`timescale 1ns / 100ps

module window_mode_informed_mean_filter_top_tb;
  import wmf_pkg::*;

  localparam int CLK_HALF = 10;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sx;
    logic signed [SAMPLE_BITS-1:0] sy;
    logic signed [SAMPLE_BITS-1:0] sz;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [LEN_BITS-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] hist [3][WINDOW_DEPTH];  // index 0 is newest
  int unsigned fill_n;
  logic [LEN_BITS-1:0] len_reg;

  sample_t pending_items [$];
  wmf_result_t expected_stats [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;
  bit items_done = 1'b0;
  bit in_taken = 1'b0;

  window_mode_informed_mean_filter_top u_top (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // statistics of one axis over the n newest samples
  task automatic axis_stats(input int ax, input int unsigned n,
                            output logic signed [SAMPLE_BITS-1:0] mode_v,
                            output logic signed [AVG_BITS-1:0] avg,
                            output logic signed [AVG_BITS-1:0] blend,
                            output logic [SPREAD_BITS-1:0] spread);
    int unsigned cnt [WINDOW_DEPTH];
    int unsigned best_i, best_c, run_i, run_c, mode_c;
    longint sum, mv, rv, num, den;
    bit first;
    best_i = 0; best_c = 0; run_i = 0; run_c = 0; mode_c = 0; sum = 0;
    for (int i = 0; i < n; i++) begin
      cnt[i] = 0;
      sum += hist[ax][i];
      first = 1'b1;
      for (int j = 0; j < i; j++)
        if (hist[ax][j] == hist[ax][i]) first = 1'b0;
      if (first)
        for (int j = i; j < n; j++)
          if (hist[ax][j] == hist[ax][i]) cnt[i]++;
    end
    for (int i = 0; i < n; i++)
      if (cnt[i] > best_c) begin
        best_c = cnt[i];
        best_i = i;
      end
    mv = hist[ax][best_i];
    for (int i = 0; i < n; i++) begin
      if (hist[ax][i] == mv) begin
        if (cnt[i] > mode_c) mode_c = cnt[i];
      end else if (cnt[i] > run_c) begin
        run_c = cnt[i];
        run_i = i;
      end
    end
    rv = hist[ax][run_i];
    num = (mode_c * mv + run_c * rv) * 16;
    den = mode_c + run_c;
    mode_v = mv[SAMPLE_BITS-1:0];
    avg = AVG_BITS'((sum * 16) / longint'(n));
    blend = AVG_BITS'(num / den);
    spread = SPREAD_BITS'(((n - mode_c - run_c) * 256) / n);
  endtask

  // one accepted sample: maybe a result, then the sample joins the window
  task automatic filter_step(input sample_t smp);
    int unsigned lim, n;
    wmf_result_t r;
    lim = len_reg < 2 ? 2 : (len_reg > WINDOW_DEPTH ? WINDOW_DEPTH : len_reg);
    n = fill_n < lim ? fill_n : lim;
    if (n >= 1) begin
      axis_stats(0, n, r.mode_x, r.average_x, r.blend_x, r.spread_x);
      axis_stats(1, n, r.mode_y, r.average_y, r.blend_y, r.spread_y);
      axis_stats(2, n, r.mode_z, r.average_z, r.blend_z, r.spread_z);
      expected_stats.insert(expected_stats.size(), r);
    end
    for (int a = 0; a < 3; a++)
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) hist[a][i] = hist[a][i-1];
    hist[0][0] = smp.sx;
    hist[1][0] = smp.sy;
    hist[2][0] = smp.sz;
    fill_n = (n + 1 < lim) ? n + 1 : lim;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
        // hold
      end else if (pending_items.size() > 0 &&
                   $urandom_range(99, 0) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending_items[0].sz, pending_items[0].sy, pending_items[0].sx};
        pending_items.delete(0);
      end else begin
        s_tvalid <= 1'b0;
      end
      m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    wmf_result_t got, exp_r;
    sample_t smp;
    cycles <= cycles + 1;
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      smp.sx = s_tdata[15:0];
      smp.sy = s_tdata[31:16];
      smp.sz = s_tdata[47:32];
      filter_step(smp);
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[RES_BITS-1:0];
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_stats[0];
        expected_stats.delete(0);
        if (got.mode_x !== exp_r.mode_x || got.mode_y !== exp_r.mode_y ||
            got.mode_z !== exp_r.mode_z)
          begin
            $display("%0t: mode exp %0d %0d %0d got %0d %0d %0d", $time, exp_r.mode_x,
                     exp_r.mode_y, exp_r.mode_z, got.mode_x, got.mode_y, got.mode_z);
            errors++;
          end
        if (got.average_x !== exp_r.average_x || got.average_y !== exp_r.average_y ||
            got.average_z !== exp_r.average_z) begin
          $display("%0t: average exp %0d %0d %0d got %0d %0d %0d", $time,
                   exp_r.average_x, exp_r.average_y, exp_r.average_z,
                   got.average_x, got.average_y, got.average_z);
          errors++;
        end
        if (got.blend_x !== exp_r.blend_x || got.blend_y !== exp_r.blend_y ||
            got.blend_z !== exp_r.blend_z) begin
          $display("%0t: blend exp %0d %0d %0d got %0d %0d %0d", $time,
                   exp_r.blend_x, exp_r.blend_y, exp_r.blend_z,
                   got.blend_x, got.blend_y, got.blend_z);
          errors++;
        end
        if (got.spread_x !== exp_r.spread_x || got.spread_y !== exp_r.spread_y ||
            got.spread_z !== exp_r.spread_z) begin
          $display("%0t: spread exp %0d %0d %0d got %0d %0d %0d", $time,
                   exp_r.spread_x, exp_r.spread_y, exp_r.spread_z,
                   got.spread_x, got.spread_y, got.spread_z);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // small value pool so modes and ties actually occur
  function automatic logic signed [SAMPLE_BITS-1:0] pick_value(input int span);
    case ($urandom_range(9, 0))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SAMPLE_BITS'($urandom);
      default: return SAMPLE_BITS'(int'($urandom_range(span, 0)) - span / 2);
    endcase
  endfunction

  task automatic add_item(input logic signed [SAMPLE_BITS-1:0] x,
                          input logic signed [SAMPLE_BITS-1:0] y,
                          input logic signed [SAMPLE_BITS-1:0] z);
    sample_t s;
    s.sx = x;
    s.sy = y;
    s.sz = z;
    pending_items.insert(pending_items.size(), s);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || s_tvalid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_BITS-1:0] v);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    len_reg = v;
  endtask

  initial begin
    int lens [8] = '{0, 1, 2, 3, 7, 32, 63, 16};
    int idle_s [4] = '{0, 83, 0, 27};
    int idle_r [4] = '{0, 0, 83, 27};
    int span;
    for (int a = 0; a < 3; a++)
      for (int i = 0; i < WINDOW_DEPTH; i++) hist[a][i] = '0;
    fill_n = 0;
    len_reg = LENGTH_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty window, extremes, single distinct value, ties
    add_item(16'sh7fff, 16'sh8000, 16'sh0000);
    add_item(16'sh7fff, 16'sh8000, 16'sh0000);
    add_item(16'sh7fff, 16'sh8000, -16'sd1);
    add_item(16'sh8000, 16'sh7fff, 16'sh5555);
    add_item(16'sh8000, 16'sh7fff, -16'sh5556);
    add_item(16'sh1234, 16'sh7fff, 16'sh5555);
    add_item(-16'sd3, 16'sd3, 16'sd0);
    add_item(-16'sd3, 16'sd3, 16'sd1);
    add_item(16'sd5, 16'sd4, 16'sd2);
    add_item(16'sd5, 16'sd4, 16'sd2);
    wait_idle();

    // random phases across window lengths and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      write_length(lens[ph]);
      send_idle_pct = idle_s[ph % 4];
      recv_stall_pct = idle_r[ph % 4];
      for (int k = 0; k < 250; k++) begin
        span = ($urandom_range(3, 0) == 0) ? 65535 : $urandom_range(6, 1);
        add_item(pick_value(span), pick_value(span), pick_value(span));
      end
      // stretch of small-span values at the end of each phase
      for (int k = 0; k < 10; k++) add_item(pick_value(3), pick_value(3), pick_value(3));
      wait_idle();
    end
    write_length(LENGTH_RESET);
    add_item(16'sd1, 16'sd2, 16'sd3);
    add_item(16'sd1, 16'sd2, 16'sd3);
    wait_idle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
